// ===== rtl/core/tarw_pkg.sv =====
package tarw_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int OQ_DEPTH        = 4;

	localparam logic [8:0]  NAME_LAST  = 9'd98;
	localparam logic [8:0]  SIZE_FIRST = 9'd124;
	localparam logic [8:0]  SIZE_LAST  = 9'd134;
	localparam logic [8:0]  TYPE_AT    = 9'd156;
	localparam logic [8:0]  HDR_LAST   = 9'd511;
	localparam logic [31:0] HDR_LEN    = 32'd512;
	localparam logic [31:0] BLK_MASK   = 32'd511;

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  entry_index;
		logic [6:0]  name_position;
		logic [7:0]  name_char;
		logic [31:0] file_size;
		logic [7:0]  type_code;
		logic [31:0] data_address;
	} res_t;

	// up to two results leave the walker per input beat
	typedef struct packed {
		logic first;
		logic second;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

// ===== rtl/core/tarw_walk.sv =====
module tarw_walk #(
	parameter int MAX_ENTRIES = tarw_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          room,
	output tarw_pkg::push_t push
);
	import tarw_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SKIP,
		PH_DONE
	} phase_t;

	phase_t        phase_q;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic [31:0]   base_q;
	logic [8:0]    off_q;
	logic [31:0]   size_q;
	logic          stop_q;
	logic [7:0]    type_q;
	logic [31:0]   skip_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   pos_q;
	logic [31:0]   hdr_addr_q;

	logic          in_acc;
	logic          go;
	logic          hdr;
	logic          zero_stop;
	logic          work;
	logic          emit_name;
	logic          emit_ent;
	logic          full;
	logic          any_done;
	logic          in_octal;
	logic [CW-1:0] cnt_nx;
	logic [CW+6:0] cnt_ext;
	logic [CW+6:0] cnt_nx_ext;
	logic [31:0]   size_round;
	logic [31:0]   skip_new;
	phase_t        phase_nx;
	res_t          name_r;
	res_t          ent_r;
	res_t          done_r;

	assign in_ready = !valid_s1 || room;
	assign in_acc   = in_valid && in_ready;
	assign go       = valid_s1 && room;

	assign cnt_ext    = {7'd0, cnt_q};
	assign cnt_nx_ext = {7'd0, cnt_nx};

	always_comb begin
		hdr        = (phase_q == PH_HEADER);
		zero_stop  = hdr && (off_q == 9'd0) && (byte_s1 == 8'd0);
		work       = hdr && !zero_stop;
		emit_name  = work && (off_q <= NAME_LAST);
		emit_ent   = work && (off_q == HDR_LAST);
		full       = emit_ent && (cnt_q == CW'(MAX_ENTRIES - 1));
		any_done   = (phase_q != PH_DONE) && (zero_stop || full || last_s1);
		in_octal   = work && (off_q >= SIZE_FIRST) && (off_q <= SIZE_LAST) && !stop_q;
		cnt_nx     = emit_ent ? cnt_q + 1'b1 : cnt_q;
		size_round = size_q + BLK_MASK;
		skip_new   = size_round & ~BLK_MASK;

		phase_nx = phase_q;
		if (phase_q == PH_SKIP && skip_q == 32'd1) begin
			phase_nx = PH_HEADER;
		end
		if (emit_ent) begin
			phase_nx = (skip_new == 32'd0) ? PH_HEADER : PH_SKIP;
		end
		if (any_done) begin
			phase_nx = PH_DONE;
		end

		name_r               = '0;
		name_r.kind          = KIND_NAME;
		name_r.entry_index   = cnt_ext[6:0];
		name_r.name_position = off_q[6:0];
		name_r.name_char     = byte_s1;

		ent_r              = '0;
		ent_r.kind         = KIND_ENTRY;
		ent_r.entry_index  = cnt_ext[6:0];
		ent_r.file_size    = size_q;
		ent_r.type_code    = type_q;
		ent_r.data_address = base_q + hdr_addr_q;

		done_r             = '0;
		done_r.kind        = KIND_DONE;
		done_r.entry_index = cnt_nx_ext[6:0];

		push.first  = go && (emit_name || emit_ent || any_done);
		push.second = go && (emit_name || emit_ent) && any_done;
		push.r0     = emit_name ? name_r : (emit_ent ? ent_r : done_r);
		push.r1     = done_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			valid_s1   <= 1'b0;
			byte_s1    <= '0;
			last_s1    <= 1'b0;
			base_q     <= '0;
			off_q      <= '0;
			size_q     <= '0;
			stop_q     <= 1'b0;
			type_q     <= '0;
			skip_q     <= '0;
			cnt_q      <= '0;
			pos_q      <= '0;
			hdr_addr_q <= HDR_LEN;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (in_acc) begin
				byte_s1 <= data_byte;
				last_s1 <= last_byte;
			end
			valid_s1 <= in_acc || (valid_s1 && !room);

			if (go && phase_q != PH_DONE) begin
				pos_q   <= pos_q + 32'd1;
				phase_q <= phase_nx;
				if (phase_q == PH_SKIP) begin
					skip_q <= skip_q - 32'd1;
				end
				if (hdr && off_q == 9'd0) begin
					// data of this entry starts one header length past here
					hdr_addr_q <= pos_q + HDR_LEN;
				end
				if (work) begin
					off_q <= off_q + 9'd1;
					if (in_octal) begin
						if (byte_s1 inside {[8'h30:8'h37]}) begin
							size_q <= {size_q[28:0], byte_s1[2:0]};
						end else begin
							stop_q <= 1'b1;
						end
					end
					if (off_q == TYPE_AT) begin
						type_q <= byte_s1;
					end
					if (emit_ent) begin
						cnt_q  <= cnt_nx;
						skip_q <= skip_new;
						size_q <= '0;
						stop_q <= 1'b0;
						type_q <= '0;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/tarw_outq.sv =====
module tarw_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  tarw_pkg::push_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_ready,
	output tarw_pkg::res_t  out_res
);
	import tarw_pkg::*;

	localparam int AW = $clog2(OQ_DEPTH);

	res_t        mem_q [OQ_DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW:0]   cnt_q;
	logic          pop;
	logic [AW:0]   n_push;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_res   = mem_q[head_q];
	// leave space for a two-result beat
	assign room      = (cnt_q <= (AW+1)'(OQ_DEPTH - 2));
	assign n_push    = (AW+1)'(push.first) + (AW+1)'(push.second);

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.second) begin
			mem_q[tail_q + 1'b1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			tail_q <= tail_q + n_push[AW-1:0];
			if (pop) begin
				head_q <= head_q + 1'b1;
			end
			cnt_q <= cnt_q + n_push - (AW+1)'(pop);
		end
	end

endmodule

// ===== rtl/core/tar_archive_header_walker.sv =====
// Streams a tar image one byte per beat and reports, per 512-byte header, the
// name bytes at offsets 0..98, then an entry record (index, octal size, type
// byte, data address = image_base + header start + 512), and skips the file
// data rounded up to 512 bytes. A zero first header byte, MAX_ENTRIES entries
// or the beat marked last ends the walk with one done result; later bytes are
// taken and dropped until reset. The block accepts one byte per cycle when
// the result queue has room; the first result of a byte goes through the
// input register and then the result queue. Results sit in a four-deep
// queue, and input stalls only while that queue cannot take the two
// results a single byte may cause. Write image_base only while idle.
module tar_archive_header_walker #(
	parameter int MAX_ENTRIES = tarw_pkg::MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [6:0]  entry_index,
	output logic [6:0]  name_position,
	output logic [7:0]  name_char,
	output logic [31:0] file_size,
	output logic [7:0]  type_code,
	output logic [31:0] data_address
);
	import tarw_pkg::*;

	push_t push;
	res_t  res;
	logic  room;

	tarw_walk #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.room      (room),
		.push      (push)
	);

	tarw_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign kind          = res.kind;
	assign entry_index   = res.entry_index;
	assign name_position = res.name_position;
	assign name_char     = res.name_char;
	assign file_size     = res.file_size;
	assign type_code     = res.type_code;
	assign data_address  = res.data_address;

endmodule

// ===== rtl/core/tarw_check.sv =====
module tarw_check (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [6:0]  name_position,
	input logic [7:0]  name_char,
	input logic [31:0] data_address
);
	import tarw_pkg::*;

	// the done beat is the last result of a walk
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_DONE |=> !out_valid)
		else $error("result after done");

	a_name_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_NAME |-> name_position <= NAME_LAST)
		else $error("name position out of range");

	a_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_NAME |-> name_position == 7'd0 && name_char == 8'd0)
		else $error("name fields set on non-name result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_address))
		else $error("stalled result changed");

endmodule

bind tar_archive_header_walker tarw_check u_check (.*);

// ===== sim/tb_top.sv =====
module tb_top;
	import tarw_pkg::*;

	localparam int ENTRY_CAP = 3;
	localparam int DIR_N = 2;

	typedef enum logic [1:0] {NM_RAMP, NM_ONES, NM_ZERO, NM_RAND} name_pat_t;
	typedef enum logic [1:0] {END_ZERO, END_LAST, END_FULL} walk_end_t;
	typedef enum logic [1:0] {WALK_HDR, WALK_SKIP, WALK_DONE} walk_t;

	// one archive header; the size field is spelled as 11 octal digits of size_digits,
	// with the digit at stop_at (if below 11) replaced by stop_ch
	typedef struct packed {
		logic        wr_base;
		logic [31:0] base;
		name_pat_t   name_pat;
		logic [32:0] size_digits;
		logic [3:0]  stop_at;
		logic [7:0]  stop_ch;
		logic [7:0]  typ;
		logic        typed;
		logic [31:0] t_size;
		logic [31:0] t_addr;
	} hdr_row_t;

	localparam hdr_row_t DIR_ROWS [DIR_N] = '{
		'{1'b1, 32'hFFFF_FFFF, NM_ONES, 33'h1_FFFF_FFFF, 4'd11, 8'h00, 8'hFF,
			1'b1, 32'hFFFF_FFFF, 32'h0000_01FF},
		'{1'b0, 32'h0000_0000, NM_RAMP, 33'o1777, 4'd9, 8'h38, 8'h4C,
			1'b0, 32'h0, 32'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [6:0]  entry_index;
	logic [6:0]  name_position;
	logic [7:0]  name_char;
	logic [31:0] file_size;
	logic [7:0]  type_code;
	logic [31:0] data_address;

	// walk state as the block should hold it
	walk_t       w_phase = WALK_HDR;
	logic [8:0]  w_off = 9'd0;
	logic [31:0] w_size = 32'd0;
	logic        w_stop = 1'b0;
	logic [7:0]  w_type = 8'd0;
	logic [31:0] w_skip = 32'd0;
	logic [31:0] w_pos = 32'd0;
	logic [31:0] w_start = 32'd0;
	int unsigned w_entries = 0;
	logic [31:0] base_now = 32'd0;

	logic        typed_on = 1'b0;
	logic [31:0] typed_size = 32'd0;
	logic [31:0] typed_addr = 32'd0;

	res_t        header_results [$];
	res_t        want;
	logic [7:0]  hdr_buf [512];

	logic        quiet_in = 1'b0;
	logic        quiet_out = 1'b0;
	int unsigned cyc_count = 0;
	int          out_hold = 0;

	int n_err = 0;
	int n_names = 0;
	int n_entries = 0;
	int n_dones = 0;
	int bytes_sent = 0;
	int hdrs_walked = 0;
	int base_writes = 0;

	tar_archive_header_walker #(
		.MAX_ENTRIES(ENTRY_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.entry_index(entry_index),
		.name_position(name_position),
		.name_char(name_char),
		.file_size(file_size),
		.type_code(type_code),
		.data_address(data_address)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic int pick_gap(input logic quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 70)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic res_t mk_res(input kind_t k, input int unsigned idx,
		input logic [6:0] pos, input logic [7:0] ch, input logic [31:0] sz,
		input logic [7:0] ty, input logic [31:0] ad);
		res_t r;
		r.kind = k;
		r.entry_index = idx[6:0];
		r.name_position = pos;
		r.name_char = ch;
		r.file_size = sz;
		r.type_code = ty;
		r.data_address = ad;
		return r;
	endfunction

	// advance the walk by one accepted byte and queue the results it causes
	function automatic void walk_byte(input logic [7:0] b, input logic lst);
		if (w_phase == WALK_DONE)
			return;
		if (w_phase == WALK_SKIP) begin
			w_skip = w_skip - 32'd1;
			if (w_skip == 32'd0)
				w_phase = WALK_HDR;
		end else begin
			if (w_off == 9'd0) begin
				w_start = w_pos;
				if (b == 8'd0) begin
					header_results.push_back(mk_res(KIND_DONE, w_entries, 0, 0, 0, 0, 0));
					w_phase = WALK_DONE;
				end
			end
			if (w_phase == WALK_HDR) begin
				if (w_off <= NAME_LAST)
					header_results.push_back(mk_res(KIND_NAME, w_entries, w_off[6:0], b,
						0, 0, 0));
				if (w_off >= SIZE_FIRST && w_off <= SIZE_LAST && !w_stop) begin
					if (b >= 8'h30 && b <= 8'h37)
						w_size = {w_size[28:0], 3'b000} + {29'd0, b[2:0]};
					else
						w_stop = 1'b1;
				end
				if (w_off == TYPE_AT)
					w_type = b;
				if (w_off == HDR_LAST) begin
					header_results.push_back(mk_res(KIND_ENTRY, w_entries, 0, 0,
						typed_on ? typed_size : w_size, w_type,
						typed_on ? typed_addr : base_now + w_start + HDR_LEN));
					w_entries++;
					w_skip = (w_size + BLK_MASK) & ~BLK_MASK;
					w_phase = (w_skip == 32'd0) ? WALK_HDR : WALK_SKIP;
					w_off = 9'd0;
					w_size = 32'd0;
					w_stop = 1'b0;
					w_type = 8'd0;
					if (w_entries >= ENTRY_CAP) begin
						header_results.push_back(mk_res(KIND_DONE, w_entries, 0, 0, 0, 0, 0));
						w_phase = WALK_DONE;
					end
				end else begin
					w_off = w_off + 9'd1;
				end
			end
		end
		w_pos = w_pos + 32'd1;
		if (lst && w_phase != WALK_DONE) begin
			header_results.push_back(mk_res(KIND_DONE, w_entries, 0, 0, 0, 0, 0));
			w_phase = WALK_DONE;
		end
	endfunction

	function automatic void chk(input string nm, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			$error("%s: expected %h, got %h", nm, e, a);
			n_err++;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst);
		int gap;
		gap = pick_gap(quiet_in);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		walk_byte(b, lst);
		bytes_sent++;
	endtask

	// drain, let skip beats settle, then write the base register
	task automatic set_base(input logic [31:0] v);
		in_valid <= 1'b0;
		while (header_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_now = v;
		base_writes++;
	endtask

	// last_at: header offset that carries last_byte, 512 for the final skip beat
	task automatic walk_header(input hdr_row_t r, input int last_at);
		int i;
		if (r.wr_base)
			set_base(r.base);
		typed_on = r.typed;
		typed_size = r.t_size;
		typed_addr = r.t_addr;
		for (i = 0; i < 512; i++)
			hdr_buf[i] = 8'($urandom);
		for (i = 0; i <= int'(NAME_LAST); i++) begin
			case (r.name_pat)
				NM_RAMP: hdr_buf[i] = 8'(i + 1);
				NM_ONES: hdr_buf[i] = 8'hFF;
				NM_ZERO: hdr_buf[i] = (i == 0) ? 8'h01 : 8'h00;
				default: ;
			endcase
		end
		// a zero here would end the walk
		if (hdr_buf[0] == 8'd0)
			hdr_buf[0] = 8'h2E;
		for (i = 0; i < 11; i++)
			hdr_buf[int'(SIZE_FIRST) + i] = 8'h30 + {5'd0, r.size_digits[3 * (10 - i) +: 3]};
		if (r.stop_at < 4'd11)
			hdr_buf[int'(SIZE_FIRST) + r.stop_at] = r.stop_ch;
		hdr_buf[TYPE_AT] = r.typ;
		for (i = 0; i < 512 && w_phase != WALK_DONE; i++)
			send_byte(hdr_buf[i], i == last_at);
		typed_on = 1'b0;
		while (w_phase == WALK_SKIP)
			send_byte(8'($urandom), last_at >= 512 && w_skip == 32'd1);
		hdrs_walked++;
	endtask

	always @(posedge clk) begin
		cyc_count++;
		if (cyc_count % 400 == 0) begin
			quiet_in <= ($urandom_range(0, 3) == 0);
			quiet_out <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		if (out_hold != 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_hold = pick_gap(quiet_out);
			out_ready <= (out_hold == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (header_results.size() == 0) begin
				$error("kind %0d beat arrived with nothing pending", kind);
				n_err++;
			end else begin
				want = header_results.pop_front();
				chk("kind", 32'(want.kind), 32'(kind));
				chk("entry_index", 32'(want.entry_index), 32'(entry_index));
				chk("name_position", 32'(want.name_position), 32'(name_position));
				chk("name_char", 32'(want.name_char), 32'(name_char));
				chk("file_size", want.file_size, file_size);
				chk("type_code", 32'(want.type_code), 32'(type_code));
				chk("data_address", want.data_address, data_address);
				case (want.kind)
					KIND_NAME: n_names++;
					KIND_ENTRY: n_entries++;
					default: n_dones++;
				endcase
			end
		end
	end

	initial begin
		hdr_row_t  row;
		walk_end_t end_mode;
		int        h;
		int        n_hdr;
		int        last_at;
		int        sel;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		end_mode = walk_end_t'($urandom_range(0, 2));
		for (h = 0; h < DIR_N; h++) begin
			last_at = -1;
			// now and then end on the final skip beat of the last directed header
			if (h == DIR_N - 1 && end_mode == END_LAST && $urandom_range(0, 2) == 0)
				last_at = 512;
			walk_header(DIR_ROWS[h], last_at);
		end

		if (w_phase == WALK_DONE || end_mode == END_ZERO)
			n_hdr = 0;
		else
			n_hdr = ENTRY_CAP - int'(w_entries);
		for (h = 0; h < n_hdr; h++) begin
			if ($urandom_range(0, 3) == 0) begin
				sel = $urandom_range(0, 3);
				set_base(sel == 0 ? 32'd0 : sel == 1 ? 32'hFFFF_FFFF : $urandom);
			end
			row = '0;
			row.name_pat = name_pat_t'($urandom_range(0, 3));
			row.typ = 8'($urandom);
			row.stop_at = 4'd11;
			row.stop_ch = 8'($urandom);
			if (row.stop_ch[7:3] == 5'b00110)
				row.stop_ch = row.stop_ch ^ 8'h40;
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				row.size_digits = 33'($urandom_range(0, 1100));
				if ($urandom_range(0, 4) == 0)
					row.stop_at = 4'($urandom_range(0, 11));
			end else if (sel == 5) begin
				row.size_digits = 33'd0;
			end else if (sel == 6) begin
				// low word near 2^32: rounding wraps and nothing is skipped
				row.size_digits = {1'($urandom), 32'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_FE01))};
			end else if (sel == 7) begin
				row.size_digits = 33'(512 * $urandom_range(1, 2) + $urandom_range(0, 2)) - 33'd1;
			end else begin
				// early stop keeps the decoded prefix short
				row.size_digits = {1'($urandom), 32'($urandom)};
				row.stop_at = 4'($urandom_range(0, 3));
			end
			last_at = -1;
			if (h == n_hdr - 1) begin
				if (end_mode == END_LAST) begin
					case ($urandom_range(0, 4))
						0: last_at = 0;
						1: last_at = int'(NAME_LAST);
						2: last_at = int'(NAME_LAST) + 1;
						3: last_at = int'(HDR_LAST);
						default: last_at = $urandom_range(0, 510);
					endcase
				end else if (end_mode == END_FULL && $urandom_range(0, 1) == 1) begin
					last_at = int'(HDR_LAST);
				end
			end
			walk_header(row, last_at);
		end
		if (w_phase != WALK_DONE)
			send_byte(end_mode == END_ZERO ? 8'h00 : 8'h41,
				end_mode != END_ZERO || $urandom_range(0, 1) == 1);

		// walk is over; these beats must be dropped
		repeat (20) send_byte(8'($urandom), 1'($urandom));
		in_valid <= 1'b0;
		while (header_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("walked %0d bytes over %0d headers, base register written %0d times",
			bytes_sent, hdrs_walked, base_writes);
		$display("saw %0d name bytes, %0d entry records, %0d done; walk ended by %s",
			n_names, n_entries, n_dones, end_mode.name());
		if (n_err == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
